### rtl/prot_pkg.sv
package prot_pkg;

  localparam int unsigned BYTE_W = 17;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned CNT_W  = 16;

  localparam logic [BYTE_W-1:0] THRESHOLD_RESET = 17'd32768;
  localparam logic [CNT_W-1:0]  CNT_MAX         = 16'hFFFF;

  typedef enum logic [1:0] {
    FUNC_QUEUE  = 2'd0,
    FUNC_REPORT = 2'd1,
    FUNC_START  = 2'd2,
    FUNC_STOP   = 2'd3
  } prot_func_e;

  typedef enum logic [1:0] {
    OUT_OK      = 2'd0,
    OUT_EMPTY   = 2'd1,
    OUT_DMA_ERR = 2'd2,
    OUT_STARTED = 2'd3
  } prot_outcome_e;

  // Command after classification by the front end
  typedef struct packed {
    prot_func_e        func;
    logic [BYTE_W-1:0] offered_fl;  // offered bytes rounded down to whole frames
    logic [POS_W-1:0]  rpos;        // read position already wrapped to the ring
    logic              pdone;
    logic              err;
    logic              dmode;
  } prot_op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] accepted_bytes;
    logic [BYTE_W-1:0] queued_level;
    logic              is_running;
    prot_outcome_e     outcome;
    logic [CNT_W-1:0]  underruns_seen;
    logic              ack_period;
  } prot_res_t;

endpackage

### rtl/prot_cmd_if.sv
interface prot_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [16:0] byte_count;
  logic [15:0] read_position;
  logic        period_done;
  logic        fifo_error;
  logic        descriptor_error;
  logic        drain_mode;

  modport source (
    output valid, func, byte_count, read_position, period_done, fifo_error,
           descriptor_error, drain_mode,
    input  ready
  );
  modport sink (
    input  valid, func, byte_count, read_position, period_done, fifo_error,
           descriptor_error, drain_mode,
    output ready
  );
endinterface

### rtl/prot_res_if.sv
interface prot_res_if;
  logic        valid;
  logic        ready;
  logic [16:0] accepted_bytes;
  logic [16:0] queued_level;
  logic        is_running;
  logic [1:0]  outcome;
  logic [15:0] underruns_seen;
  logic        ack_period;

  modport source (
    output valid, accepted_bytes, queued_level, is_running, outcome, underruns_seen,
           ack_period,
    input  ready
  );
  modport sink (
    input  valid, accepted_bytes, queued_level, is_running, outcome, underruns_seen,
           ack_period,
    output ready
  );
endinterface

### rtl/prot_front.sv
module prot_front import prot_pkg::*; #(
  parameter int unsigned RING_BYTES  = 65536,
  parameter int unsigned FRAME_BYTES = 4
) (
  prot_cmd_if.sink   cmd_i,
  input  logic       full_i,
  output logic       push_o,
  output prot_op_t   op_o
);

  // floor(x / d) as (x * ceil(2^S / d)) >> S, exact for x < 2^N when S = N + clog2(d)
  localparam int unsigned FS = BYTE_W + $clog2(FRAME_BYTES);
  localparam longint unsigned FRECIP_L = ((64'd1 << FS) + FRAME_BYTES - 1) / FRAME_BYTES;
  localparam logic [BYTE_W+1:0] FRECIP = (BYTE_W+2)'(FRECIP_L);

  localparam int unsigned RS = POS_W + $clog2(RING_BYTES);
  localparam longint unsigned RRECIP_L = ((64'd1 << RS) + RING_BYTES - 1) / RING_BYTES;
  localparam logic [POS_W+1:0] RRECIP = (POS_W+2)'(RRECIP_L);

  logic [2*BYTE_W+1:0] fprod;
  logic [BYTE_W-1:0]   fq;
  logic [2*POS_W+1:0]  rprod;
  logic [POS_W-1:0]    rq;
  logic [31:0]         rsub;

  always_comb begin
    fprod = cmd_i.byte_count * FRECIP;
    fq    = BYTE_W'(fprod >> FS);
    rprod = cmd_i.read_position * RRECIP;
    rq    = POS_W'(rprod >> RS);
    rsub  = 32'(cmd_i.read_position) - 32'(rq) * 32'(RING_BYTES);

    op_o.func       = prot_func_e'(cmd_i.func);
    op_o.offered_fl = BYTE_W'(32'(fq) * 32'(FRAME_BYTES));
    op_o.rpos       = POS_W'(rsub);
    op_o.pdone      = cmd_i.period_done;
    op_o.err        = cmd_i.fifo_error | cmd_i.descriptor_error;
    op_o.dmode      = cmd_i.drain_mode;
  end

  assign cmd_i.ready = ~full_i;
  assign push_o      = cmd_i.valid & ~full_i;

endmodule

### rtl/prot_queue.sv
module prot_queue import prot_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  prot_op_t op_i,
  output logic     full_o,
  output logic     valid_o,
  output prot_op_t op_o,
  input  logic     pop_i
);

  prot_op_t   ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign op_o    = ent_q[rd_q];

  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= op_i;
    end
  end

endmodule

### rtl/prot_back.sv
module prot_back import prot_pkg::*; #(
  parameter int unsigned RING_BYTES  = 65536,
  parameter int unsigned FRAME_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  input  logic              op_valid_i,
  input  prot_op_t          op_i,
  output logic              pop_o,
  prot_res_if.source        res_o
);

  localparam int unsigned QW = $clog2(RING_BYTES + 1);
  localparam int unsigned OW = $clog2(RING_BYTES);
  localparam int unsigned AW = (QW > BYTE_W) ? QW : BYTE_W;
  localparam logic [QW-1:0] RING_Q = QW'(RING_BYTES);

  localparam int unsigned FS = QW + $clog2(FRAME_BYTES);
  localparam longint unsigned FRECIP_L = ((64'd1 << FS) + FRAME_BYTES - 1) / FRAME_BYTES;
  localparam logic [QW+1:0] FRECIP = (QW+2)'(FRECIP_L);

  logic [BYTE_W-1:0] thr_q;
  logic [QW-1:0]     queued_q, queued_d;
  logic [OW-1:0]     last_q, last_d;
  logic              run_q, run_d;
  logic              drain_q, drain_d;
  logic [CNT_W-1:0]  under_q, under_d;
  logic              out_vld_q;
  prot_res_t         res_q, res_d;

  logic [QW-1:0]     room;
  logic [2*QW+1:0]   rprod;
  logic [QW-1:0]     room_fl;
  logic [AW-1:0]     acc;
  logic [OW-1:0]     rpos;
  logic [QW-1:0]     adv;
  logic              take;

  assign take  = op_valid_i & (~out_vld_q | res_o.ready);
  assign pop_o = take;

  always_comb begin
    queued_d = queued_q;
    last_d   = last_q;
    run_d    = run_q;
    drain_d  = drain_q;
    under_d  = under_q;
    res_d    = '0;
    acc      = '0;

    room    = RING_Q - queued_q;
    rprod   = room * FRECIP;
    room_fl = QW'(QW'(rprod >> FS) * FRAME_BYTES);
    rpos    = OW'(op_i.rpos);
    if (rpos >= last_q) begin
      adv = QW'(rpos - last_q);
    end else begin
      adv = RING_Q - QW'(last_q) + QW'(rpos);
    end
    if (adv == '0 && op_i.pdone) begin
      adv = RING_Q;
    end

    case (op_i.func)
      FUNC_QUEUE: begin
        if (!run_q && queued_q == '0) begin
          last_d = '0;
        end
        acc = (AW'(op_i.offered_fl) < AW'(room_fl)) ? AW'(op_i.offered_fl) : AW'(room_fl);
        queued_d = queued_q + QW'(acc);
        if (!run_q && AW'(queued_d) >= AW'(thr_q)) begin
          last_d           = '0;
          run_d            = 1'b1;
          res_d.outcome    = OUT_STARTED;
          res_d.ack_period = 1'b1;
        end
      end
      FUNC_REPORT: begin
        if (run_q) begin
          if (op_i.err) begin
            queued_d         = '0;
            last_d           = '0;
            run_d            = 1'b0;
            res_d.outcome    = OUT_DMA_ERR;
            res_d.ack_period = 1'b1;
          end else begin
            res_d.ack_period = op_i.pdone;
            last_d           = rpos;
            if (adv != '0) begin
              if (adv >= queued_q) begin
                if (!drain_q && under_q != CNT_MAX) begin
                  under_d = under_q + CNT_W'(1);
                end
                queued_d         = '0;
                last_d           = '0;
                run_d            = 1'b0;
                res_d.outcome    = OUT_EMPTY;
                res_d.ack_period = 1'b1;
              end else begin
                queued_d = queued_q - adv;
              end
            end
          end
        end
      end
      FUNC_START: begin
        drain_d = op_i.dmode;
        if (!run_q) begin
          last_d           = '0;
          run_d            = 1'b1;
          res_d.outcome    = OUT_STARTED;
          res_d.ack_period = 1'b1;
        end
      end
      default: begin
        queued_d         = '0;
        last_d           = '0;
        run_d            = 1'b0;
        drain_d          = 1'b0;
        res_d.ack_period = 1'b1;
      end
    endcase

    res_d.accepted_bytes = BYTE_W'(acc);
    res_d.queued_level   = BYTE_W'(queued_d);
    res_d.is_running     = run_d;
    res_d.underruns_seen = under_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= THRESHOLD_RESET;
      queued_q  <= '0;
      last_q    <= '0;
      run_q     <= 1'b0;
      drain_q   <= 1'b0;
      under_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (take) begin
        queued_q <= queued_d;
        last_q   <= last_d;
        run_q    <= run_d;
        drain_q  <= drain_d;
        under_q  <= under_d;
      end
      if (take) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.accepted_bytes = res_q.accepted_bytes;
  assign res_o.queued_level   = res_q.queued_level;
  assign res_o.is_running     = res_q.is_running;
  assign res_o.outcome        = res_q.outcome;
  assign res_o.underruns_seen = res_q.underruns_seen;
  assign res_o.ack_period     = res_q.ack_period;

endmodule

### rtl/playback_ring_occupancy_tracker.sv
// Occupancy accounting for a circular playback DMA ring.
//
// cmd_i carries one command per beat (queue bytes, position report, start,
// stop and clear); res_o returns exactly one result beat per command, in
// order. Both are valid/ready channels; a beat moves when both are high.
// cfg_we_i/cfg_wdata_i write the auto-start threshold in any cycle.
//
// A command beat lands in a two-entry queue; the state unit takes the queue
// head and registers its result, so a command passes through a queue entry
// and then the result register. With res_o.ready held high the block moves
// one beat per cycle on both sides. If the receiver stalls, the result
// register holds, the queue fills, and cmd_i.ready drops once two commands
// are waiting; it rises again in the cycle after a result beat is taken.
// The critical path is the frame round-down of the free space (one constant
// multiply) feeding the min, the add and the threshold compare.
//
// Reset clears all accounting state and empties the queue; the threshold
// returns to 32768 bytes.
module playback_ring_occupancy_tracker import prot_pkg::*; #(
  parameter int unsigned RING_BYTES  = 65536,
  parameter int unsigned FRAME_BYTES = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  prot_cmd_if.sink          cmd_i,
  prot_res_if.source        res_o
);

  logic     push;
  logic     full;
  logic     q_valid;
  logic     pop;
  prot_op_t op_in;
  prot_op_t op_head;

  prot_front #(
    .RING_BYTES (RING_BYTES),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .cmd_i (cmd_i),
    .full_i(full),
    .push_o(push),
    .op_o  (op_in)
  );

  prot_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (op_in),
    .full_o (full),
    .valid_o(q_valid),
    .op_o   (op_head),
    .pop_i  (pop)
  );

  prot_back #(
    .RING_BYTES (RING_BYTES),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .op_valid_i (q_valid),
    .op_i       (op_head),
    .pop_o      (pop),
    .res_o      (res_o)
  );

`ifndef NO_ASSERTIONS
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.outcome == OUT_STARTED |-> res_o.is_running)
    else $error("start result without running");

  a_stop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.outcome == OUT_EMPTY || res_o.outcome == OUT_DMA_ERR)
      |-> !res_o.is_running && res_o.queued_level == '0)
    else $error("stop result with ring not cleared");

  a_change_acks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.outcome != OUT_OK |-> res_o.ack_period)
    else $error("run state change without status clear");

  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ready |-> q_valid && !pop || res_o.valid)
    else $error("command side stalled with nothing pending");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import prot_pkg::*;

  localparam logic [BYTE_W-1:0] RING_SPAN  = 17'h10000;
  localparam logic [BYTE_W-1:0] FRAME_MASK = ~17'd3;  // 4-byte frames
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 3000;

  typedef struct packed {
    prot_func_e        func;
    logic [BYTE_W-1:0] byte_count;
    logic [POS_W-1:0]  read_position;
    logic              period_done;
    logic              fifo_error;
    logic              descriptor_error;
    logic              drain_mode;
  } ring_cmd_t;

  // Tracks the ring accounting and holds the results still owed by the block
  class ring_scoreboard;
    logic [BYTE_W-1:0] threshold;
    logic [BYTE_W-1:0] queued;
    logic [POS_W-1:0]  wr_off;
    logic [POS_W-1:0]  rd_off;
    logic              running;
    logic              draining;
    logic [CNT_W-1:0]  underruns;
    prot_res_t         pending_res[$];
    int                mismatches;

    function new();
      threshold  = THRESHOLD_RESET;
      halt_ring();
      draining   = 1'b0;
      underruns  = '0;
      mismatches = 0;
    endfunction

    function void halt_ring();
      running = 1'b0;
      queued  = '0;
      wr_off  = '0;
      rd_off  = '0;
    endfunction

    function void note_cmd(ring_cmd_t c);
      prot_res_t         r;
      logic [BYTE_W-1:0] room;
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] adv;
      acc = '0;
      r.outcome    = OUT_OK;
      r.ack_period = 1'b0;
      case (c.func)
        FUNC_QUEUE: begin
          if (!running && queued == '0) begin
            wr_off = '0;
            rd_off = '0;
          end
          room = (queued < RING_SPAN) ? RING_SPAN - queued : '0;
          acc  = (c.byte_count < room) ? c.byte_count : room;
          acc  = acc & FRAME_MASK;
          wr_off = wr_off + acc[POS_W-1:0];
          queued = queued + acc;
          if (!running && queued >= threshold) begin
            rd_off  = '0;
            running = 1'b1;
            r.outcome    = OUT_STARTED;
            r.ack_period = 1'b1;
          end
        end
        FUNC_REPORT: begin
          if (running) begin
            if (c.fifo_error || c.descriptor_error) begin
              halt_ring();
              r.outcome    = OUT_DMA_ERR;
              r.ack_period = 1'b1;
            end else begin
              if (c.period_done) r.ack_period = 1'b1;
              if (c.read_position >= rd_off)
                adv = BYTE_W'(c.read_position) - BYTE_W'(rd_off);
              else
                adv = RING_SPAN - BYTE_W'(rd_off) + BYTE_W'(c.read_position);
              // no movement across a completed period means a full lap
              if (adv == '0 && c.period_done) adv = RING_SPAN;
              rd_off = c.read_position;
              if (adv != '0) begin
                if (adv >= queued) begin
                  if (!draining && underruns != CNT_MAX) underruns = underruns + CNT_W'(1);
                  halt_ring();
                  r.outcome    = OUT_EMPTY;
                  r.ack_period = 1'b1;
                end else begin
                  queued = queued - adv;
                end
              end
            end
          end
        end
        FUNC_START: begin
          draining = c.drain_mode;
          if (!running) begin
            rd_off  = '0;
            running = 1'b1;
            r.outcome    = OUT_STARTED;
            r.ack_period = 1'b1;
          end
        end
        default: begin
          halt_ring();
          draining     = 1'b0;
          r.ack_period = 1'b1;
        end
      endcase
      r.accepted_bytes = acc;
      r.queued_level   = queued;
      r.is_running     = running;
      r.underruns_seen = underruns;
      pending_res.push_back(r);
    endfunction

    function void note_mismatch(string what, prot_res_t want, prot_res_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch on %s: ", $realtime, what,
                 "want acc=%0d lvl=%0d run=%0b out=%0d urun=%0d ack=%0b, ",
                 want.accepted_bytes, want.queued_level, want.is_running, want.outcome,
                 want.underruns_seen, want.ack_period,
                 "got acc=%0d lvl=%0d run=%0b out=%0d urun=%0d ack=%0b",
                 got.accepted_bytes, got.queued_level, got.is_running, got.outcome,
                 got.underruns_seen, got.ack_period);
    endfunction

    function void check_res(prot_res_t got);
      prot_res_t want;
      if (pending_res.size() == 0) begin
        note_mismatch("result beat with no command waiting", '0, got);
      end else begin
        want = pending_res.pop_front();
        if (got.accepted_bytes !== want.accepted_bytes)
          note_mismatch("accepted_bytes", want, got);
        if (got.queued_level !== want.queued_level)
          note_mismatch("queued_level", want, got);
        if (got.is_running !== want.is_running)
          note_mismatch("is_running", want, got);
        if (got.outcome !== want.outcome)
          note_mismatch("outcome", want, got);
        if (got.underruns_seen !== want.underruns_seen)
          note_mismatch("underruns_seen", want, got);
        if (got.ack_period !== want.ack_period)
          note_mismatch("ack_period", want, got);
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [BYTE_W-1:0] cfg_wdata;

  prot_cmd_if cmd_bus();
  prot_res_if res_bus();

  ring_scoreboard sb = new();

  bit settle_mode = 1'b0;  // no idling on either side
  bit hold_req    = 1'b0;

  playback_ring_occupancy_tracker #(
    .RING_BYTES  (65536),
    .FRAME_BYTES (4)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .cmd_i       (cmd_bus),
    .res_o       (res_bus)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Beat monitor: both channels sampled at the edge
  always @(posedge clk_i) begin
    ring_cmd_t seen_cmd;
    prot_res_t seen_res;
    if (rst_ni) begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        seen_cmd.func             = prot_func_e'(cmd_bus.func);
        seen_cmd.byte_count       = cmd_bus.byte_count;
        seen_cmd.read_position    = cmd_bus.read_position;
        seen_cmd.period_done      = cmd_bus.period_done;
        seen_cmd.fifo_error       = cmd_bus.fifo_error;
        seen_cmd.descriptor_error = cmd_bus.descriptor_error;
        seen_cmd.drain_mode       = cmd_bus.drain_mode;
        sb.note_cmd(seen_cmd);
      end
      if (res_bus.valid && res_bus.ready) begin
        seen_res.accepted_bytes = res_bus.accepted_bytes;
        seen_res.queued_level   = res_bus.queued_level;
        seen_res.is_running     = res_bus.is_running;
        seen_res.outcome        = prot_outcome_e'(res_bus.outcome);
        seen_res.underruns_seen = res_bus.underruns_seen;
        seen_res.ack_period     = res_bus.ack_period;
        sb.check_res(seen_res);
      end
    end
  end

  // Receiver: random stalls, free-running stretches, and a long hold-off on request
  initial begin : result_sink
    int hold_left;
    int stall_left;
    int run_left;
    int pick;
    hold_left  = 0;
    stall_left = 0;
    run_left   = 0;
    res_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        res_bus.ready <= 1'b0;
      end else if (settle_mode) begin
        res_bus.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else if (run_left > 0) begin
        run_left--;
        res_bus.ready <= 1'b1;
      end else begin
        pick = $urandom_range(0, 15);
        if (pick < 3) begin
          stall_left = $urandom_range(1, 11) - 1;
          res_bus.ready <= 1'b0;
        end else if (pick == 3) begin
          run_left = $urandom_range(30, 80);
          res_bus.ready <= 1'b1;
        end else begin
          res_bus.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int dead_cycles;
    dead_cycles = 0;
    @(posedge rst_ni);
    while (dead_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready))
        dead_cycles = 0;
      else
        dead_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // All driver tasks start and end just after a rising edge
  task automatic send_cmd(ring_cmd_t c);
    cmd_bus.valid            <= 1'b1;
    cmd_bus.func             <= c.func;
    cmd_bus.byte_count       <= c.byte_count;
    cmd_bus.read_position    <= c.read_position;
    cmd_bus.period_done      <= c.period_done;
    cmd_bus.fifo_error       <= c.fifo_error;
    cmd_bus.descriptor_error <= c.descriptor_error;
    cmd_bus.drain_mode       <= c.drain_mode;
    do @(posedge clk_i); while (!cmd_bus.ready);
  endtask

  task automatic push_cmd(prot_func_e f, int unsigned bytes, int unsigned rpos,
                          bit pd, bit fe, bit de, bit dm);
    ring_cmd_t c;
    c.func             = f;
    c.byte_count       = BYTE_W'(bytes);
    c.read_position    = POS_W'(rpos);
    c.period_done      = pd;
    c.fifo_error       = fe;
    c.descriptor_error = de;
    c.drain_mode       = dm;
    send_cmd(c);
  endtask

  task automatic idle_cycles(int n);
    cmd_bus.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_results_done();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_res.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [BYTE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.threshold = value;
  endtask

  // Mostly well-formed traffic steered by the predicted ring state
  function automatic ring_cmd_t make_random_cmd();
    ring_cmd_t   c;
    int unsigned q;
    int unsigned adv;
    int unsigned pick;
    q    = sb.queued;
    pick = $urandom_range(0, 99);
    c.func             = FUNC_QUEUE;
    c.byte_count       = BYTE_W'($urandom_range(0, 65536));
    c.read_position    = POS_W'($urandom);
    c.period_done      = ($urandom_range(0, 3) == 0);
    c.fifo_error       = ($urandom_range(0, 24) == 0);
    c.descriptor_error = ($urandom_range(0, 24) == 0);
    c.drain_mode       = 1'($urandom_range(0, 1));
    if (pick < 40) begin
      c.func = FUNC_QUEUE;
      case ($urandom_range(0, 9))
        0:       c.byte_count = RING_SPAN;
        1, 2:    c.byte_count = BYTE_W'($urandom_range(0, 65536));
        default: c.byte_count = BYTE_W'($urandom_range(1, 8192));
      endcase
    end else if (pick < 75) begin
      c.func = FUNC_REPORT;
      case ($urandom_range(0, 19))
        0, 1, 2, 3: adv = $urandom_range(0, 65535);
        4, 5, 6:    adv = q + $urandom_range(0, 3);  // lands near empty
        default:    adv = $urandom_range(0, (q >> 1) + 1);
      endcase
      c.read_position = POS_W'(int'(sb.rd_off) + adv);
    end else if (pick < 90) begin
      c.func = FUNC_START;
    end else if (pick < 94) begin
      c.func = FUNC_STOP;
    end else begin
      c.func = prot_func_e'($urandom_range(0, 3));
    end
    return c;
  endfunction

  task automatic run_random(int n, int pause_at);
    bit idle_ok;
    idle_ok = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) idle_ok = $urandom_range(0, 2) != 0;
      if (i == pause_at) wait_results_done();
      if (!settle_mode && idle_ok && $urandom_range(0, 4) == 0)
        idle_cycles($urandom_range(1, 11));
      send_cmd(make_random_cmd());
    end
  endtask

  initial begin : main_seq
    logic [BYTE_W-1:0] phase_thresh[5];
    rst_ni    = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    cmd_bus.valid            = 1'b0;
    cmd_bus.func             = FUNC_QUEUE;
    cmd_bus.byte_count       = '0;
    cmd_bus.read_position    = '0;
    cmd_bus.period_done      = 1'b0;
    cmd_bus.fifo_error       = 1'b0;
    cmd_bus.descriptor_error = 1'b0;
    cmd_bus.drain_mode       = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed, reset threshold
    push_cmd(FUNC_REPORT, 0, 1234, 1, 1, 1, 0);   // ignored while stopped
    push_cmd(FUNC_QUEUE, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_QUEUE, 3, 0, 0, 0, 0, 0);       // less than a frame
    push_cmd(FUNC_QUEUE, 65536, 0, 0, 0, 0, 0);   // fills ring, auto-start
    push_cmd(FUNC_QUEUE, 100, 0, 0, 0, 0, 0);     // no room
    push_cmd(FUNC_START, 0, 0, 0, 0, 0, 1);       // already running, drain on
    push_cmd(FUNC_REPORT, 0, 0, 1, 0, 0, 0);      // full lap while draining
    push_cmd(FUNC_STOP, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_QUEUE, 40001, 0, 0, 0, 0, 0);
    push_cmd(FUNC_REPORT, 0, 1000, 0, 0, 0, 0);
    push_cmd(FUNC_REPORT, 0, 1000, 0, 0, 0, 0);   // no advance
    push_cmd(FUNC_REPORT, 0, 1000, 1, 0, 0, 0);   // full lap, underrun
    push_cmd(FUNC_START, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_REPORT, 0, 65535, 0, 0, 0, 0);
    push_cmd(FUNC_START, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_REPORT, 0, 7, 1, 1, 0, 0);      // fifo error
    push_cmd(FUNC_START, 0, 0, 0, 0, 0, 1);
    push_cmd(FUNC_REPORT, 0, 7, 0, 0, 1, 0);      // descriptor error
    push_cmd(FUNC_QUEUE, 30000, 0, 0, 0, 0, 0);
    push_cmd(FUNC_QUEUE, 2767, 0, 0, 0, 0, 0);
    push_cmd(FUNC_QUEUE, 4, 0, 0, 0, 0, 0);       // reaches threshold exactly
    push_cmd(FUNC_QUEUE, 65535, 0, 0, 0, 0, 0);   // capped by free space
    push_cmd(FUNC_REPORT, 0, 30000, 0, 0, 0, 0);
    push_cmd(FUNC_REPORT, 0, 29999, 0, 0, 0, 0);  // wraps almost a lap
    push_cmd(FUNC_STOP, 0, 0, 0, 0, 0, 0);
    wait_results_done();

    phase_thresh[0] = '0;
    phase_thresh[1] = RING_SPAN;
    phase_thresh[2] = 17'd1;
    phase_thresh[3] = BYTE_W'($urandom_range(0, 65536));
    phase_thresh[4] = 17'd4096;
    for (int p = 0; p < 5; p++) begin
      write_threshold(phase_thresh[p]);
      push_cmd(FUNC_QUEUE, 0, 0, 0, 0, 0, 0);
      if (p == 1) begin
        run_random(40, -1);
        hold_req = 1'b1;  // receiver goes quiet, sender keeps offering
        run_random(40, -1);
      end
      run_random(300, (p == 2) ? 150 : -1);
      wait_results_done();
    end

    settle_mode = 1'b1;
    write_threshold(17'd16384);
    run_random(200, -1);
    wait_results_done();

    // back-to-back underruns on an empty ring
    for (int i = 0; i < 20; i++) begin
      push_cmd(FUNC_START, 0, 0, 0, 0, 0, 0);
      push_cmd(FUNC_REPORT, 0, 1, 0, 0, 0, 0);
    end
    push_cmd(FUNC_STOP, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_START, 0, 0, 0, 0, 0, 0);
    push_cmd(FUNC_REPORT, 0, 9, 1, 0, 0, 0);
    wait_results_done();
    repeat (10) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending_res.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/prot_pkg.sv
rtl/prot_cmd_if.sv
rtl/prot_res_if.sv
rtl/prot_front.sv
rtl/prot_queue.sv
rtl/prot_back.sv
rtl/playback_ring_occupancy_tracker.sv
tb/sv/tb_top.sv
